// ===== sv/iqdem_pkg.sv =====
// ----------------------------------------------------------------------------
// iqdem_pkg
// Shared types, register indexes and CORDIC angle table for the IQ demodulator.
// ----------------------------------------------------------------------------
package iqdem_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 8;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int MODE_W      = 2;
    localparam int DECIM_W     = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE       = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECIMATION = 1'b1;

    localparam logic [DECIM_W-1:0] DECIM_RESET = 8'd4;

    localparam int CORDIC_STEPS = 16;
    // step counter covers both the cordic loop and a root of up to 32 bits
    localparam int STEP_W       = 5;
    localparam int ATAN_W       = 30;
    localparam int ZW           = 34;

    typedef enum logic [MODE_W-1:0] {
        MODE_AM  = 2'd0,
        MODE_FM  = 2'd1,
        MODE_USB = 2'd2,
        MODE_LSB = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_FOLD,
        ST_CORDIC,
        ST_SQRT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              load;
        logic              mul_first;
        logic              mul_second;
        logic              fold;
        logic              cordic_step;
        logic              sqrt_step;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic  emit;
        logic  out_free;
        mode_t mode;
    } dp_status_t;

    // atan(2^-k) in units of 2^-32 turn
    function automatic logic [ATAN_W-1:0] atan_turns(input logic [STEP_W-1:0] k);
        logic [ATAN_W-1:0] v;
        unique case (k)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10680862;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/iqdem_ctrl.sv =====
// ----------------------------------------------------------------------------
// iqdem_ctrl
// Sequencer for the demodulator: multiply passes, cordic and square root loops.
// ----------------------------------------------------------------------------
module iqdem_ctrl
    import iqdem_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST   = STEP_W'(SAMPLE_WIDTH - 1);

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = '0;
        in_stall   = 1'b1;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
                if (in_valid && status.emit)
                begin
                    if (status.mode == MODE_AM || status.mode == MODE_FM)
                        state_next = ST_MUL_A;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_MUL_A:
            begin
                cmd.mul_first = 1'b1;
                state_next    = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.mul_second = 1'b1;
                if (status.mode == MODE_AM)
                    state_next = ST_SQRT;
                else
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (step_reg == CORDIC_LAST)
                    state_next = ST_FINISH;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == SQRT_LAST)
                    state_next = ST_FINISH;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_FINISH:
            begin
                cmd.out_load = status.out_free;
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/iqdem_datapath.sv =====
// ----------------------------------------------------------------------------
// iqdem_datapath
// Registers, shared multipliers, cordic vectoring unit, bit-serial square root,
// decimation counter and the output register.
// ----------------------------------------------------------------------------
module iqdem_datapath
    import iqdem_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] q_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] audio,
    input  dp_cmd_t                        cmd,
    output dp_status_t                     status
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int PW    = 2 * SW;
    localparam int SUMW  = PW + 1;
    localparam int XW    = PW + 3;
    localparam int RW    = ZW + 3;
    localparam int CMPW  = (COUNT_WIDTH > DECIM_W) ? COUNT_WIDTH : DECIM_W;
    localparam int H_INT = 1 << (SW - 1);
    localparam int FM_SHIFT = 32 - SW;

    localparam logic signed [RW-1:0] SAT_HI = RW'(H_INT - 1);
    localparam logic signed [RW-1:0] SAT_LO = RW'(-H_INT);
    localparam logic signed [RW-1:0] H_WIDE = RW'(H_INT);
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(64'sd2147483648);

    mode_t                   mode_reg;
    logic [DECIM_W-1:0]      decim_reg;
    logic [COUNT_WIDTH-1:0]  count_reg;
    logic signed [SW-1:0]    prev_i_reg;
    logic signed [SW-1:0]    prev_q_reg;
    logic                    out_valid_reg;

    logic signed [SW-1:0]    ci_reg;
    logic signed [SW-1:0]    cq_reg;
    logic signed [SW-1:0]    pi_reg;
    logic signed [SW-1:0]    pq_reg;
    logic signed [PW-1:0]    prod_a_reg;
    logic signed [PW-1:0]    prod_b_reg;
    logic signed [SUMW-1:0]  sum_reg;
    logic signed [XW-1:0]    x_reg;
    logic signed [XW-1:0]    y_reg;
    logic signed [ZW-1:0]    z_reg;
    logic                    zero_reg;
    logic [SW+1:0]           rem_reg;
    logic [SW-1:0]           root_reg;
    logic signed [SW-1:0]    audio_reg;

    logic                    emit;
    logic                    out_free;
    logic signed [SW-1:0]    mul_a_l;
    logic signed [SW-1:0]    mul_a_r;
    logic signed [SW-1:0]    mul_b_l;
    logic signed [SW-1:0]    mul_b_r;
    logic signed [PW-1:0]    mul_a;
    logic signed [PW-1:0]    mul_b;
    logic signed [SUMW-1:0]  im_val;
    logic signed [XW-1:0]    re_ext;
    logic signed [XW-1:0]    im_ext;
    logic signed [XW-1:0]    xs;
    logic signed [XW-1:0]    ys;
    logic signed [ZW-1:0]    atan_k;
    logic [SW+1:0]           rem_shift;
    logic [SW+1:0]           trial;
    logic signed [RW-1:0]    z_ext;
    logic signed [RW-1:0]    z_scaled;
    logic signed [RW-1:0]    res_wide;
    logic signed [RW-1:0]    res_sat;

    assign emit     = CMPW'(count_reg) >= CMPW'(decim_reg);
    assign out_free = !out_valid_reg || !out_stall;

    assign status.emit     = emit;
    assign status.out_free = out_free;
    assign status.mode     = mode_reg;

    assign out_valid = out_valid_reg;
    assign audio     = audio_reg;

    // two shared multipliers: squares for am, products of current and previous samples for fm
    always_comb
    begin
        if (cmd.mul_second)
        begin
            mul_a_l = cq_reg;
            mul_a_r = pi_reg;
            mul_b_l = ci_reg;
            mul_b_r = pq_reg;
        end
        else
        begin
            mul_a_l = ci_reg;
            mul_b_l = cq_reg;
            mul_a_r = (mode_reg == MODE_AM) ? ci_reg : pi_reg;
            mul_b_r = (mode_reg == MODE_AM) ? cq_reg : pq_reg;
        end
    end

    assign mul_a = mul_a_l * mul_a_r;
    assign mul_b = mul_b_l * mul_b_r;

    assign im_val = SUMW'(prod_a_reg) - SUMW'(prod_b_reg);
    assign re_ext = XW'(sum_reg);
    assign im_ext = XW'(im_val);

    assign xs     = x_reg >>> cmd.step;
    assign ys     = y_reg >>> cmd.step;
    assign atan_k = ZW'(atan_turns(cmd.step));

    assign rem_shift = {rem_reg[SW-1:0], sum_reg[PW-1:PW-2]};
    assign trial     = {root_reg, 2'b01};

    assign z_ext    = RW'(z_reg);
    assign z_scaled = ((z_ext <<< 2) + z_ext) >>> FM_SHIFT;

    always_comb
    begin
        unique case (mode_reg)
            MODE_AM:  res_wide = RW'(signed'({1'b0, root_reg, 1'b0})) - H_WIDE;
            MODE_FM:  res_wide = zero_reg ? '0 : z_scaled;
            MODE_USB: res_wide = RW'(ci_reg) <<< 1;
            MODE_LSB: res_wide = RW'(cq_reg) <<< 1;
            default:  res_wide = '0;
        endcase
        if (res_wide > SAT_HI)
            res_sat = SAT_HI;
        else if (res_wide < SAT_LO)
            res_sat = SAT_LO;
        else
            res_sat = res_wide;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_FM;
            decim_reg     <= DECIM_RESET;
            count_reg     <= '0;
            prev_i_reg    <= '0;
            prev_q_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_MODE)
                    mode_reg <= mode_t'(cfg_data[MODE_W-1:0]);
                else if (cfg_index == REG_DECIMATION)
                    decim_reg <= cfg_data[DECIM_W-1:0];
            end
            if (cmd.load)
            begin
                prev_i_reg <= i_sample;
                prev_q_reg <= q_sample;
                if (emit)
                    count_reg <= '0;
                else
                    count_reg <= count_reg + 1'b1;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ci_reg <= i_sample;
            cq_reg <= q_sample;
            pi_reg <= prev_i_reg;
            pq_reg <= prev_q_reg;
        end
        if (cmd.mul_first || cmd.mul_second)
        begin
            prod_a_reg <= mul_a;
            prod_b_reg <= mul_b;
        end
        if (cmd.mul_second)
        begin
            sum_reg  <= SUMW'(prod_a_reg) + SUMW'(prod_b_reg);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.fold)
        begin
            zero_reg <= (sum_reg == '0) && (im_val == '0);
            if (sum_reg < 0)
            begin
                x_reg <= -re_ext;
                y_reg <= -im_ext;
                z_reg <= (im_val >= 0) ? Z_HALF : -Z_HALF;
            end
            else
            begin
                x_reg <= re_ext;
                y_reg <= im_ext;
                z_reg <= '0;
            end
        end
        if (cmd.cordic_step)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_k;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_k;
            end
        end
        if (cmd.sqrt_step)
        begin
            sum_reg <= sum_reg <<< 2;
            if (rem_shift >= trial)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[SW-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
            audio_reg <= res_sat[SW-1:0];
    end

endmodule

// ===== sv/iq_am_fm_ssb_demodulator_core.sv =====
// ----------------------------------------------------------------------------
// iq_am_fm_ssb_demodulator_core
// AM / FM / USB / LSB demodulator for complex baseband samples with decimation.
// ----------------------------------------------------------------------------
// One input item is taken per cycle while no result is being worked on; an item
// that produces no audio sample (decimation) is done once taken. An item that
// produces a sample goes straight to the output register in USB or LSB mode; in
// AM mode it takes two multiplier passes and a bit-serial square root (one root
// bit per cycle), and in FM mode two passes through the shared multiplier pair,
// fold, sixteen CORDIC vectoring steps and the final scaling. The output register
// lets the next item enter while the previous audio sample still waits on out_stall.
module iq_am_fm_ssb_demodulator_core
    import iqdem_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] q_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] audio
);

    dp_cmd_t    cmd;
    dp_status_t status;

    iqdem_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    iqdem_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .i_sample  (i_sample),
        .q_sample  (q_sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .audio     (audio),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
